/* rtl/mcw_pkg.sv */
// ----------------------------------------------------------------------------
// mcw_pkg
// Shared types and constants of the minimum covering window block.
// ----------------------------------------------------------------------------
package mcw_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int SYMBOL_W = 8;
    localparam int START_W  = 12;
    localparam int LENGTH_W = 13;

    // Item modes.
    localparam logic MODE_TARGET = 1'b0;
    localparam logic MODE_TEXT   = 1'b1;

    // One input item: a target character or a text byte.
    typedef struct packed {
        logic                mode;
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
    } item_t;

    // One result item, produced by the final text byte.
    typedef struct packed {
        logic                found;
        logic [START_W-1:0]  window_start;
        logic [LENGTH_W-1:0] window_length;
        logic                overflow;
    } result_t;

endpackage

/* rtl/mcw_stream_if.sv */
// ----------------------------------------------------------------------------
// mcw_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface mcw_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    // The source drives the payload, the sink takes it.
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

/* rtl/mcw_ram.sv */
// ----------------------------------------------------------------------------
// mcw_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/minimum_covering_window_core.sv */
// ----------------------------------------------------------------------------
// minimum_covering_window_core
// Finds the shortest text window that holds every target character.
// ----------------------------------------------------------------------------
// The block takes target characters (mode 0) and then text bytes (mode 1),
// one transaction at a time, and on the text byte marked last it returns one
// result with the shortest covering window (earliest on a tie) and an
// overflow flag, then clears its counts. A target byte reads its count entry
// and writes it back; a text byte does the same and is stored in the text
// memory. Then the window is checked for full coverage, and each step of the
// left window edge reads the text memory at that edge and then reads and
// writes back the count entry of the byte that leaves; every byte leaves the
// window at most once. The final byte then loads the result register, which
// frees the input side while the result waits. Counts are cleared at once
// through per-symbol valid bits, so there is no clearing pass after reset or
// after a result.
module minimum_covering_window_core #(
    parameter int TEXT_DEPTH    = 4096,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    mcw_stream_if.sink   item,
    mcw_stream_if.source result
);

    import mcw_pkg::*;

    localparam int POS_W   = $clog2(TEXT_DEPTH + 1);
    localparam int TEXT_AW = $clog2(TEXT_DEPTH);
    localparam int SYM_AW  = $clog2(ALPHABET_SIZE);
    localparam int CNT_W   = POS_W;
    localparam int ENT_W   = 2 * CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TGT_WR,
        ST_TXT_WR,
        ST_SHR_CHK,
        ST_SHR_TXT,
        ST_SHR_WR,
        ST_EMIT
    } state_t;

    // True when a symbol lies inside the alphabet.
    function automatic logic in_alpha(input logic [SYMBOL_W-1:0] sym);
        return ({1'b0, sym} < (SYMBOL_W + 1)'(ALPHABET_SIZE));
    endfunction

    state_t                   state_reg, state_next;
    logic                     mode_reg, mode_next;
    logic                     last_reg, last_next;
    logic [SYMBOL_W-1:0]      sym_reg, sym_next;
    logic                     alpha_reg, alpha_next;
    logic [SYM_AW-1:0]        cnt_addr_reg, cnt_addr_next;
    logic [POS_W-1:0]         target_reg, target_next;
    logic [POS_W-1:0]         matched_reg, matched_next;
    logic [POS_W-1:0]         right_reg, right_next;
    logic [POS_W-1:0]         left_reg, left_next;
    logic [TEXT_AW-1:0]       best_start_reg, best_start_next;
    logic [POS_W-1:0]         best_len_reg, best_len_next;
    logic                     best_vld_reg, best_vld_next;
    logic                     ovf_reg, ovf_next;
    logic [ALPHABET_SIZE-1:0] ent_vld_reg, ent_vld_next;
    logic                     out_vld_reg, out_vld_next;
    result_t                  out_data_reg, out_data_next;

    // Memory ports.
    logic                     cnt_we, cnt_re;
    logic [SYM_AW-1:0]        cnt_raddr;
    logic [ENT_W-1:0]         cnt_wdata, cnt_rdata;
    logic                     txt_we, txt_re;
    logic [TEXT_AW-1:0]       txt_raddr;
    logic [SYMBOL_W-1:0]      txt_rdata;

    // Count entry as read, with never-written entries reading as zero.
    logic [CNT_W-1:0]         ent_needed, ent_window;
    logic [CNT_W-1:0]         win_inc, win_dec;
    logic [POS_W-1:0]         win_len;
    logic                     covered;

    // Needed and window counts per symbol, packed into one word.
    mcw_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_addr_reg),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Text bytes by position.
    mcw_ram #(
        .WIDTH (SYMBOL_W),
        .DEPTH (TEXT_DEPTH)
    ) u_text_ram (
        .clk   (clk),
        .we    (txt_we),
        .waddr (right_reg[TEXT_AW-1:0]),
        .wdata (sym_reg),
        .re    (txt_re),
        .raddr (txt_raddr),
        .rdata (txt_rdata)
    );

    assign ent_needed = ent_vld_reg[cnt_addr_reg] ? cnt_rdata[ENT_W-1:CNT_W] : '0;
    assign ent_window = ent_vld_reg[cnt_addr_reg] ? cnt_rdata[CNT_W-1:0] : '0;
    assign win_inc    = ent_window + 1'b1;
    assign win_dec    = (ent_window != '0) ? ent_window - 1'b1 : ent_window;
    assign win_len    = right_reg - left_reg;
    assign covered    = (target_reg != '0) && (matched_reg == target_reg)
                        && (left_reg < right_reg);

    assign item.ready  = (state_reg == ST_IDLE);
    assign result.valid = out_vld_reg;
    assign result.data  = out_data_reg;

    // Sequencer: read, modify and write back the count entries.
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        last_next       = last_reg;
        sym_next        = sym_reg;
        alpha_next      = alpha_reg;
        cnt_addr_next   = cnt_addr_reg;
        target_next     = target_reg;
        matched_next    = matched_reg;
        right_next      = right_reg;
        left_next       = left_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        best_vld_next   = best_vld_reg;
        ovf_next        = ovf_reg;
        ent_vld_next    = ent_vld_reg;
        out_data_next   = out_data_reg;
        out_vld_next    = out_vld_reg && !result.ready;

        cnt_we    = 1'b0;
        cnt_re    = 1'b0;
        cnt_raddr = item.data.symbol[SYM_AW-1:0];
        cnt_wdata = {ent_needed, ent_window};
        txt_we    = 1'b0;
        txt_re    = 1'b0;
        txt_raddr = left_reg[TEXT_AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    mode_next     = item.data.mode;
                    last_next     = item.data.last;
                    sym_next      = item.data.symbol;
                    alpha_next    = in_alpha(item.data.symbol);
                    cnt_addr_next = item.data.symbol[SYM_AW-1:0];
                    state_next    = ST_SHR_CHK;
                    if (item.data.mode == MODE_TARGET)
                    begin
                        if (in_alpha(item.data.symbol))
                        begin
                            if (target_reg >= POS_W'(TEXT_DEPTH))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                cnt_re     = 1'b1;
                                state_next = ST_TGT_WR;
                            end
                        end
                    end
                    else if (right_reg >= POS_W'(TEXT_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cnt_re     = in_alpha(item.data.symbol);
                        state_next = ST_TXT_WR;
                    end
                end
            end

            ST_TGT_WR:
            begin
                // A surplus in the window covers the new target byte at once.
                if (ent_window > ent_needed)
                begin
                    matched_next = matched_reg + 1'b1;
                end
                cnt_we                     = 1'b1;
                cnt_wdata                  = {ent_needed + 1'b1, ent_window};
                ent_vld_next[cnt_addr_reg] = 1'b1;
                target_next                = target_reg + 1'b1;
                state_next                 = ST_SHR_CHK;
            end

            ST_TXT_WR:
            begin
                txt_we     = 1'b1;
                right_next = right_reg + 1'b1;
                if (alpha_reg)
                begin
                    if (win_inc <= ent_needed)
                    begin
                        matched_next = matched_reg + 1'b1;
                    end
                    cnt_we                     = 1'b1;
                    cnt_wdata                  = {ent_needed, win_inc};
                    ent_vld_next[cnt_addr_reg] = 1'b1;
                end
                state_next = ST_SHR_CHK;
            end

            ST_SHR_CHK:
            begin
                if (covered)
                begin
                    // Keep the earlier window on a tie.
                    if (!best_vld_reg || (win_len < best_len_reg))
                    begin
                        best_vld_next   = 1'b1;
                        best_start_next = left_reg[TEXT_AW-1:0];
                        best_len_next   = win_len;
                    end
                    txt_re     = 1'b1;
                    state_next = ST_SHR_TXT;
                end
                else if ((mode_reg == MODE_TEXT) && last_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SHR_TXT:
            begin
                // Byte at the left edge selects the count entry to update.
                alpha_next    = in_alpha(txt_rdata);
                cnt_addr_next = txt_rdata[SYM_AW-1:0];
                cnt_raddr     = txt_rdata[SYM_AW-1:0];
                cnt_re        = in_alpha(txt_rdata);
                state_next    = ST_SHR_WR;
            end

            ST_SHR_WR:
            begin
                if (alpha_reg)
                begin
                    if (win_dec < ent_needed)
                    begin
                        matched_next = matched_reg - 1'b1;
                    end
                    cnt_we                     = 1'b1;
                    cnt_wdata                  = {ent_needed, win_dec};
                    ent_vld_next[cnt_addr_reg] = 1'b1;
                end
                left_next  = left_reg + 1'b1;
                state_next = ST_SHR_CHK;
            end

            ST_EMIT:
            begin
                if (!out_vld_reg || result.ready)
                begin
                    out_vld_next                = 1'b1;
                    out_data_next.found         = best_vld_reg;
                    out_data_next.window_start  = best_vld_reg ?
                                                  START_W'(best_start_reg) : '0;
                    out_data_next.window_length = best_vld_reg ?
                                                  LENGTH_W'(best_len_reg) : '0;
                    out_data_next.overflow      = ovf_reg;
                    // Clear every count and position for the next search.
                    ent_vld_next    = '0;
                    target_next     = '0;
                    matched_next    = '0;
                    right_next      = '0;
                    left_next       = '0;
                    best_start_next = '0;
                    best_len_next   = '0;
                    best_vld_next   = 1'b0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_TARGET;
            last_reg       <= 1'b0;
            sym_reg        <= '0;
            alpha_reg      <= 1'b0;
            cnt_addr_reg   <= '0;
            target_reg     <= '0;
            matched_reg    <= '0;
            right_reg      <= '0;
            left_reg       <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            best_vld_reg   <= 1'b0;
            ovf_reg        <= 1'b0;
            ent_vld_reg    <= '0;
            out_vld_reg    <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            last_reg       <= last_next;
            sym_reg        <= sym_next;
            alpha_reg      <= alpha_next;
            cnt_addr_reg   <= cnt_addr_next;
            target_reg     <= target_next;
            matched_reg    <= matched_next;
            right_reg      <= right_next;
            left_reg       <= left_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            best_vld_reg   <= best_vld_next;
            ovf_reg        <= ovf_next;
            ent_vld_reg    <= ent_vld_next;
            out_vld_reg    <= out_vld_next;
            out_data_reg   <= out_data_next;
        end
    end

`ifndef ASSERT_OFF
    // The matched total never exceeds the number of target bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        matched_reg <= target_reg)
    else $error("matched total exceeds target total");

    // The left edge never passes the right edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= right_reg)
    else $error("window left edge passed right edge");

    // An accepted transaction always holds off the input in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
    else $error("input accepted twice in a row");

    // A recorded best window is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        best_vld_reg |-> (best_len_reg != '0))
    else $error("best window has zero length");
`endif

endmodule

/* verif/mcw_window_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcw_window_checker
// Watches both channels of the covering window block, computes the expected
// shortest covering window for every final text byte and compares it, field
// by field, with each result transaction that the block delivers.
// ----------------------------------------------------------------------------
module mcw_window_checker #(
    parameter int TEXT_DEPTH = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_ready,
    input  mcw_pkg::item_t   item_data,
    input  logic             result_valid,
    input  logic             result_ready,
    input  mcw_pkg::result_t result_data,
    output int               mismatch_count,
    output int               pending_count
);

    import mcw_pkg::*;

    // Every 8-bit symbol lies inside the 256-entry alphabet.
    localparam int NUM_SYMBOLS = 256;

    logic [LENGTH_W-1:0] need_cnt [NUM_SYMBOLS];
    logic [LENGTH_W-1:0] win_cnt [NUM_SYMBOLS];
    logic [SYMBOL_W-1:0] text_mem [TEXT_DEPTH];
    logic [LENGTH_W-1:0] target_total;
    logic [LENGTH_W-1:0] matched_total;
    logic [LENGTH_W-1:0] right_pos;
    logic [LENGTH_W-1:0] left_pos;
    logic [LENGTH_W-1:0] best_len;
    logic [START_W-1:0]  best_start;
    logic                best_valid;
    logic                overflow_seen;
    result_t             expected_windows [$];
    int                  mismatches;

    // Return counts, positions, the best window and the overflow flag to zero;
    // the text memory keeps its old contents.
    task automatic clear_counts();
        for (int k = 0; k < NUM_SYMBOLS; k++)
        begin
            need_cnt[k] = '0;
            win_cnt[k]  = '0;
        end
        target_total  = '0;
        matched_total = '0;
        right_pos     = '0;
        left_pos      = '0;
        best_len      = '0;
        best_start    = '0;
        best_valid    = 1'b0;
        overflow_seen = 1'b0;
    endtask

    // While the window covers the whole target, record it if it is strictly
    // shorter than the best so far and move the left edge one byte right.
    task automatic tighten_window();
        logic [SYMBOL_W-1:0] s;
        while (target_total != 0 && matched_total == target_total &&
               left_pos < right_pos)
        begin
            if (!best_valid || (right_pos - left_pos) < best_len)
            begin
                best_valid = 1'b1;
                best_start = left_pos[START_W-1:0];
                best_len   = right_pos - left_pos;
            end
            s = text_mem[left_pos % TEXT_DEPTH];
            if (win_cnt[s] != 0)
                win_cnt[s]--;
            if (win_cnt[s] < need_cnt[s])
                matched_total--;
            left_pos++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t             want;
        logic [SYMBOL_W-1:0] sym;
        if (!rst_n)
        begin
            clear_counts();
            expected_windows.delete();
            mismatches = 0;
        end
        else
        begin
            // Result side: compare against the oldest expected window.
            if (result_valid && result_ready)
            begin
                if (expected_windows.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: found=%0d start=%0d length=%0d overflow=%0d",
                                 result_data.found, result_data.window_start,
                                 result_data.window_length, result_data.overflow);
                end
                else
                begin
                    want = expected_windows.pop_front();
                    if (want.found !== result_data.found ||
                        want.window_start !== result_data.window_start ||
                        want.window_length !== result_data.window_length ||
                        want.overflow !== result_data.overflow)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Result mismatch: expected found=%0d start=%0d ",
                                      "length=%0d overflow=%0d, got found=%0d start=%0d ",
                                      "length=%0d overflow=%0d"},
                                     want.found, want.window_start, want.window_length,
                                     want.overflow, result_data.found,
                                     result_data.window_start, result_data.window_length,
                                     result_data.overflow);
                    end
                end
            end

            // Input side: update the counts for each accepted transaction.
            if (item_valid && item_ready)
            begin
                sym = item_data.symbol;
                if (item_data.mode == MODE_TARGET)
                begin
                    // A target byte beyond the store depth is dropped.
                    if (target_total >= TEXT_DEPTH)
                        overflow_seen = 1'b1;
                    else
                    begin
                        // A surplus already in the window matches at once.
                        if (win_cnt[sym] > need_cnt[sym])
                            matched_total++;
                        need_cnt[sym]++;
                        target_total++;
                    end
                    tighten_window();
                end
                else
                begin
                    // A text byte beyond the store depth is dropped, but a
                    // final byte still closes the search.
                    if (right_pos >= TEXT_DEPTH)
                        overflow_seen = 1'b1;
                    else
                    begin
                        text_mem[right_pos % TEXT_DEPTH] = sym;
                        right_pos++;
                        win_cnt[sym]++;
                        if (win_cnt[sym] <= need_cnt[sym])
                            matched_total++;
                    end
                    tighten_window();
                    if (item_data.last)
                    begin
                        want.found         = best_valid;
                        want.window_start  = best_valid ? best_start : '0;
                        want.window_length = best_valid ? best_len : '0;
                        want.overflow      = overflow_seen;
                        expected_windows.push_back(want);
                        clear_counts();
                    end
                end
            end
        end
        mismatch_count <= mismatches;
        pending_count  <= expected_windows.size();
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the minimum covering window block.
// Drives directed cases and random target/text sequences with random gaps
// on both channels; a separate checker predicts and compares every result
// transaction.
// ----------------------------------------------------------------------------
module testbench;

    import mcw_pkg::*;

    localparam int TEXT_DEPTH   = 4096;
    localparam int RANDOM_ITEMS = 900;
    localparam int STALL_LIMIT  = 200000;

    logic clk;
    logic rst_n;
    logic gaps_on;
    int   mismatch_count;
    int   pending_count;
    int   idle_cycles = 0;

    mcw_stream_if #(.payload_t(item_t))   item_ch ();
    mcw_stream_if #(.payload_t(result_t)) result_ch ();

    minimum_covering_window_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    mcw_window_checker #(
        .TEXT_DEPTH (TEXT_DEPTH)
    ) window_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_ch.valid),
        .item_ready     (item_ch.ready),
        .item_data      (item_ch.data),
        .result_valid   (result_ch.valid),
        .result_ready   (result_ch.ready),
        .result_data    (result_ch.data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: stall at random while gaps are enabled.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= 26);
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Send one input transaction, after an optional random gap, and return
    // at the edge where it is accepted.
    task automatic send_item(input logic m, input logic [SYMBOL_W-1:0] s, input logic l);
        item_t it;
        it.mode   = m;
        it.symbol = s;
        it.last   = l;
        while (gaps_on && $urandom_range(0, 99) < 26)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    initial
    begin
        logic [SYMBOL_W-1:0] letters [4];
        logic [SYMBOL_W-1:0] sym;
        int                  n_letters;
        int                  n_target;
        int                  n_text;
        int                  sent;

        rst_n         <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        gaps_on = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty target with extreme symbols: not found.
        send_item(MODE_TEXT, 8'h00, 1'b0);
        send_item(MODE_TEXT, 8'hFF, 1'b1);

        // Extreme target symbols; the last flag on a target byte is ignored.
        send_item(MODE_TARGET, 8'hFF, 1'b1);
        send_item(MODE_TARGET, 8'h00, 1'b0);
        send_item(MODE_TEXT, 8'h00, 1'b0);
        send_item(MODE_TEXT, 8'h5A, 1'b0);
        send_item(MODE_TEXT, 8'hFF, 1'b1);

        // Two windows of equal length: the earlier one stays.
        send_item(MODE_TARGET, 8'h61, 1'b0);
        send_item(MODE_TEXT, 8'h61, 1'b0);
        send_item(MODE_TEXT, 8'h62, 1'b0);
        send_item(MODE_TEXT, 8'h61, 1'b1);

        // A repeated target byte must be covered with multiplicity.
        send_item(MODE_TARGET, 8'h61, 1'b0);
        send_item(MODE_TARGET, 8'h61, 1'b0);
        send_item(MODE_TEXT, 8'h61, 1'b0);
        send_item(MODE_TEXT, 8'h62, 1'b0);
        send_item(MODE_TEXT, 8'h61, 1'b0);
        send_item(MODE_TEXT, 8'h61, 1'b1);

        // A target byte after text that the window already holds in surplus.
        send_item(MODE_TEXT, 8'h78, 1'b0);
        send_item(MODE_TEXT, 8'h78, 1'b0);
        send_item(MODE_TARGET, 8'h78, 1'b0);
        send_item(MODE_TEXT, 8'h79, 1'b1);

        // Target never seen in the text: not found.
        send_item(MODE_TARGET, 8'h71, 1'b0);
        send_item(MODE_TEXT, 8'h72, 1'b1);

        // Random sequences over small alphabets, with some noise.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            gaps_on = !(sent >= 300 && sent < 450);
            n_letters = $urandom_range(1, 4);
            for (int k = 0; k < 4; k++)
                letters[k] = SYMBOL_W'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 85)
            begin
                n_target = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
                n_text   = $urandom_range(1, 24);
                for (int k = 0; k < n_target; k++)
                    send_item(MODE_TARGET, letters[$urandom_range(0, n_letters - 1)],
                              1'($urandom_range(0, 1)));
                for (int k = 0; k < n_text; k++)
                begin
                    // Now and then a target byte arrives in the middle of the text.
                    if ($urandom_range(0, 19) == 0)
                    begin
                        send_item(MODE_TARGET, letters[$urandom_range(0, n_letters - 1)],
                                  1'b0);
                        sent++;
                    end
                    if ($urandom_range(0, 99) < 80)
                        sym = letters[$urandom_range(0, n_letters - 1)];
                    else
                        sym = SYMBOL_W'($urandom_range(0, 255));
                    send_item(MODE_TEXT, sym, k == n_text - 1);
                end
                sent += n_target + n_text;
            end
            else
            begin
                n_text = $urandom_range(1, 8);
                for (int k = 0; k < n_text; k++)
                    send_item(1'($urandom_range(0, 1)),
                              SYMBOL_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                sent += n_text;
            end
        end

        // Drain the outstanding results, then watch for stray ones.
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
